/* hw/rtl/psru_pkg.sv */
package psru_pkg;

  // Default sizes
  localparam int GRID_POINTS_DEF = 256;
  localparam int FRAC_BITS_DEF   = 24;

  localparam int DATA_W      = 32;
  localparam int WIDE_W      = 48;
  localparam int IDX_W       = 8;
  localparam int REG_IDX_W   = 8;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 104;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int SCR_AW      = 5;
  localparam int SCR_DEPTH   = 32;
  localparam int STEP_W      = 6;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_DIFF      = 8'd0;
  localparam logic [REG_IDX_W-1:0] REG_BETA      = 8'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAMMA     = 8'd2;
  localparam logic [REG_IDX_W-1:0] REG_MU_SLOPE  = 8'd3;
  localparam logic [REG_IDX_W-1:0] REG_MU_OFFSET = 8'd4;
  localparam logic [REG_IDX_W-1:0] REG_XI        = 8'd5;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    word_t rho;
    word_t p;
    word_t q;
  } point_t;

  // One rate evaluation: left, center and right neighbor
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    point_t           b;
    point_t           c;
    point_t           a;
    logic             last;
  } job_t;

  typedef struct packed {
    word_t diff;
    word_t beta;
    word_t gamma;
    word_t mu_slope;
    word_t mu_offset;
    word_t xi;
  } coef_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    word_t            dr;
    word_t            pr;
    word_t            qr;
    logic             sat;
    logic             last;
  } res_t;

  typedef struct packed {
    logic  done;
    logic  sat;
    wide_t res;
  } mul_rsp_t;

  typedef struct packed {
    logic  sat;
    wide_t val;
  } wsat_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } nsat_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_FETCH, BK_EXEC, BK_MULW, BK_EMIT
  } bk_state_t;

  typedef enum logic [1:0] {
    MS_IDLE, MS_PROD, MS_ROUND
  } mul_state_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_LAPA, OP_LAPB, OP_OUTD, OP_OUTP, OP_OUTQ
  } op_t;

  // Operand sources: fixed sources below 32, scratch entries from 32 up
  localparam logic [5:0] SRC_B_RHO  = 6'd0;
  localparam logic [5:0] SRC_B_P    = 6'd1;
  localparam logic [5:0] SRC_B_Q    = 6'd2;
  localparam logic [5:0] SRC_C_RHO  = 6'd3;
  localparam logic [5:0] SRC_C_P    = 6'd4;
  localparam logic [5:0] SRC_C_Q    = 6'd5;
  localparam logic [5:0] SRC_A_RHO  = 6'd6;
  localparam logic [5:0] SRC_A_P    = 6'd7;
  localparam logic [5:0] SRC_A_Q    = 6'd8;
  localparam logic [5:0] SRC_DIFF   = 6'd9;
  localparam logic [5:0] SRC_BETA   = 6'd10;
  localparam logic [5:0] SRC_GAMMA  = 6'd11;
  localparam logic [5:0] SRC_MUS    = 6'd12;
  localparam logic [5:0] SRC_MUO    = 6'd13;
  localparam logic [5:0] SRC_XI     = 6'd14;
  localparam logic [5:0] SRC_HALF   = 6'd15;
  localparam logic [5:0] SRC_QUART  = 6'd16;
  localparam logic [5:0] SRC_EIGHTH = 6'd17;

  typedef struct packed {
    op_t         op;
    logic [4:0]  dst;
    logic [5:0]  sx;
    logic [5:0]  sy;
    logic        fin;
  } uop_t;

  function automatic logic [5:0] sc(input logic [4:0] a);
    return {1'b1, a};
  endfunction

  function automatic uop_t mk(input op_t op, input logic [4:0] dst,
                              input logic [5:0] sx, input logic [5:0] sy,
                              input logic fin);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.sx  = sx;
    u.sy  = sy;
    u.fin = fin;
    return u;
  endfunction

  // Rate program, one entry per step of the shared datapath
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] s);
    uop_t u;
    unique case (s)
      6'd0:  u = mk(OP_MUL,  5'd0,  SRC_B_P,  SRC_B_P,    1'b0);
      6'd1:  u = mk(OP_MUL,  5'd1,  SRC_B_Q,  SRC_B_Q,    1'b0);
      6'd2:  u = mk(OP_SUB,  5'd2,  sc(5'd0), sc(5'd1),   1'b0);
      6'd3:  u = mk(OP_MUL,  5'd3,  SRC_C_P,  SRC_C_P,    1'b0);
      6'd4:  u = mk(OP_MUL,  5'd4,  SRC_C_Q,  SRC_C_Q,    1'b0);
      6'd5:  u = mk(OP_SUB,  5'd5,  sc(5'd3), sc(5'd4),   1'b0);
      6'd6:  u = mk(OP_ADD,  5'd6,  sc(5'd3), sc(5'd4),   1'b0);
      6'd7:  u = mk(OP_MUL,  5'd0,  SRC_A_P,  SRC_A_P,    1'b0);
      6'd8:  u = mk(OP_MUL,  5'd1,  SRC_A_Q,  SRC_A_Q,    1'b0);
      6'd9:  u = mk(OP_SUB,  5'd7,  sc(5'd0), sc(5'd1),   1'b0);
      6'd10: u = mk(OP_MUL,  5'd8,  SRC_B_P,  SRC_B_Q,    1'b0);
      6'd11: u = mk(OP_MUL,  5'd9,  SRC_C_P,  SRC_C_Q,    1'b0);
      6'd12: u = mk(OP_MUL,  5'd10, SRC_A_P,  SRC_A_Q,    1'b0);
      6'd13: u = mk(OP_MUL,  5'd0,  SRC_MUS,  SRC_C_RHO,  1'b0);
      6'd14: u = mk(OP_ADD,  5'd11, sc(5'd0), SRC_MUO,    1'b0);
      6'd15: u = mk(OP_MUL,  5'd12, SRC_GAMMA, SRC_C_Q,   1'b0);
      6'd16: u = mk(OP_MUL,  5'd13, SRC_XI,   sc(5'd6),   1'b0);
      6'd17: u = mk(OP_LAPA, 5'd0,  SRC_B_P,  SRC_A_P,    1'b0);
      6'd18: u = mk(OP_LAPB, 5'd14, SRC_C_P,  SRC_C_P,    1'b0);
      6'd19: u = mk(OP_MUL,  5'd0,  SRC_DIFF, sc(5'd14),  1'b0);
      6'd20: u = mk(OP_MUL,  5'd15, sc(5'd0), SRC_HALF,   1'b0);
      6'd21: u = mk(OP_OUTD, 5'd0,  sc(5'd15), sc(5'd15), 1'b0);
      6'd22: u = mk(OP_LAPA, 5'd0,  SRC_B_RHO, SRC_A_RHO, 1'b0);
      6'd23: u = mk(OP_LAPB, 5'd0,  SRC_C_RHO, SRC_C_RHO, 1'b0);
      6'd24: u = mk(OP_MUL,  5'd1,  SRC_DIFF, sc(5'd0),   1'b0);
      6'd25: u = mk(OP_MUL,  5'd16, sc(5'd1), SRC_QUART,  1'b0);
      6'd26: u = mk(OP_LAPA, 5'd0,  sc(5'd2), sc(5'd7),   1'b0);
      6'd27: u = mk(OP_LAPB, 5'd0,  sc(5'd5), sc(5'd5),   1'b0);
      6'd28: u = mk(OP_MUL,  5'd1,  SRC_BETA, sc(5'd0),   1'b0);
      6'd29: u = mk(OP_MUL,  5'd0,  sc(5'd1), SRC_QUART,  1'b0);
      6'd30: u = mk(OP_ADD,  5'd16, sc(5'd16), sc(5'd0),  1'b0);
      6'd31: u = mk(OP_LAPA, 5'd0,  SRC_B_Q,  SRC_A_Q,    1'b0);
      6'd32: u = mk(OP_LAPB, 5'd0,  SRC_C_Q,  SRC_C_Q,    1'b0);
      6'd33: u = mk(OP_MUL,  5'd1,  sc(5'd12), sc(5'd0),  1'b0);
      6'd34: u = mk(OP_MUL,  5'd0,  sc(5'd1), SRC_EIGHTH, 1'b0);
      6'd35: u = mk(OP_ADD,  5'd16, sc(5'd16), sc(5'd0),  1'b0);
      6'd36: u = mk(OP_MUL,  5'd0,  sc(5'd11), SRC_C_P,   1'b0);
      6'd37: u = mk(OP_ADD,  5'd16, sc(5'd16), sc(5'd0),  1'b0);
      6'd38: u = mk(OP_MUL,  5'd0,  sc(5'd13), SRC_C_P,   1'b0);
      6'd39: u = mk(OP_SUB,  5'd16, sc(5'd16), sc(5'd0),  1'b0);
      6'd40: u = mk(OP_OUTP, 5'd0,  sc(5'd16), sc(5'd16), 1'b0);
      6'd41: u = mk(OP_LAPA, 5'd0,  sc(5'd8), sc(5'd10),  1'b0);
      6'd42: u = mk(OP_LAPB, 5'd0,  sc(5'd9), sc(5'd9),   1'b0);
      6'd43: u = mk(OP_MUL,  5'd1,  SRC_BETA, sc(5'd0),   1'b0);
      6'd44: u = mk(OP_MUL,  5'd17, sc(5'd1), SRC_HALF,   1'b0);
      6'd45: u = mk(OP_MUL,  5'd0,  sc(5'd12), sc(5'd14), 1'b0);
      6'd46: u = mk(OP_MUL,  5'd1,  sc(5'd0), SRC_EIGHTH, 1'b0);
      6'd47: u = mk(OP_SUB,  5'd17, sc(5'd17), sc(5'd1),  1'b0);
      6'd48: u = mk(OP_MUL,  5'd0,  sc(5'd11), SRC_C_Q,   1'b0);
      6'd49: u = mk(OP_ADD,  5'd17, sc(5'd17), sc(5'd0),  1'b0);
      6'd50: u = mk(OP_MUL,  5'd0,  sc(5'd13), SRC_C_Q,   1'b0);
      6'd51: u = mk(OP_SUB,  5'd17, sc(5'd17), sc(5'd0),  1'b0);
      default: u = mk(OP_OUTQ, 5'd0, sc(5'd17), sc(5'd17), 1'b1);
    endcase
    return u;
  endfunction

  // Saturate a widened sum to the 48-bit working range
  function automatic wsat_t clamp_wide(input logic signed [51:0] v);
    wsat_t r;
    if (v > 52'sh0_7FFF_FFFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 48'sh7FFF_FFFF_FFFF;
    end else if (v < 52'shF_8000_0000_0000) begin
      r.sat = 1'b1;
      r.val = 48'sh8000_0000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[WIDE_W-1:0];
    end
    return r;
  endfunction

  // Saturate a working value to a 32-bit rate
  function automatic nsat_t clamp_out(input wide_t v);
    nsat_t r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < 48'shFFFF_8000_0000) begin
      r.sat = 1'b1;
      r.val = 32'sh8000_0000;
    end else begin
      r.sat = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/psru_queue.sv */
module psru_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  psru_pkg::job_t              push_data,
  output logic                        full,
  input  logic                        pop,
  output psru_pkg::job_t              pop_data,
  output logic                        empty,
  output logic [psru_pkg::QUEUE_AW:0] count
);

  psru_pkg::job_t                mem_r [psru_pkg::QUEUE_DEPTH];
  logic [psru_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [psru_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [psru_pkg::QUEUE_AW:0]   cnt_r;

  assign full     = (cnt_r == (psru_pkg::QUEUE_AW+1)'(psru_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign count    = cnt_r;

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
      if ((push && !full) && !(pop && !empty)) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/psru_front.sv */
module psru_front #(
  parameter int GRID_POINTS = psru_pkg::GRID_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [psru_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                            in_tlast,
  output logic                            q_push,
  output psru_pkg::job_t                  q_job,
  input  logic                            q_full
);

  localparam int CNT_W = $clog2(GRID_POINTS);

  psru_pkg::point_t first0_r, first1_r, recent0_r, recent1_r;
  logic [CNT_W-1:0] cnt_r;
  psru_pkg::job_t   pend_r [3];
  logic [1:0]       n_r, pos_r;

  psru_pkg::point_t cur;
  psru_pkg::job_t   j0_nxt, j1_nxt, j2_nxt;
  logic [1:0]       n_nxt;
  logic [CNT_W-1:0] km1;
  logic             is_last, accept;

  function automatic psru_pkg::job_t mkjob(input logic [psru_pkg::IDX_W-1:0] idx,
                                           input psru_pkg::point_t b,
                                           input psru_pkg::point_t c,
                                           input psru_pkg::point_t a,
                                           input logic last);
    psru_pkg::job_t j;
    j.idx  = idx;
    j.b    = b;
    j.c    = c;
    j.a    = a;
    j.last = last;
    return j;
  endfunction

  assign in_tready = (pos_r == n_r);
  assign accept    = in_tvalid && in_tready;
  assign q_push    = (pos_r != n_r) && !q_full;
  assign q_job     = pend_r[pos_r];

  assign cur.rho = in_tdata[31:0];
  assign cur.p   = in_tdata[63:32];
  assign cur.q   = in_tdata[95:64];
  assign km1     = cnt_r - 1'b1;
  assign is_last = in_tlast || (cnt_r == CNT_W'(GRID_POINTS - 1));

  // Classify the point: which results it completes
  always_comb begin
    j0_nxt = mkjob('0, cur, cur, cur, 1'b1);
    j1_nxt = j0_nxt;
    j2_nxt = j0_nxt;
    n_nxt  = 2'd0;
    if (cnt_r == '0) begin
      if (is_last) n_nxt = 2'd1;
    end else if (cnt_r == CNT_W'(1)) begin
      if (is_last) begin
        j0_nxt = mkjob('0, cur, first0_r, cur, 1'b0);
        j1_nxt = mkjob(8'd1, first0_r, cur, first0_r, 1'b1);
        n_nxt  = 2'd2;
      end
    end else begin
      j0_nxt = mkjob(8'(km1), recent0_r, recent1_r, cur, 1'b0);
      n_nxt  = 2'd1;
      if (is_last) begin
        j1_nxt = mkjob(8'(cnt_r), recent1_r, cur, first0_r, 1'b0);
        j2_nxt = mkjob('0, cur, first0_r, first1_r, 1'b1);
        n_nxt  = 2'd3;
      end
    end
  end

  // Window state and pending result list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first0_r  <= '0;
      first1_r  <= '0;
      recent0_r <= '0;
      recent1_r <= '0;
      cnt_r     <= '0;
      n_r       <= '0;
      pos_r     <= '0;
    end else if (accept) begin
      if (cnt_r == '0) first0_r <= cur;
      if (cnt_r == CNT_W'(1)) first1_r <= cur;
      recent0_r <= recent1_r;
      recent1_r <= cur;
      cnt_r     <= is_last ? '0 : cnt_r + 1'b1;
      pend_r[0] <= j0_nxt;
      pend_r[1] <= j1_nxt;
      pend_r[2] <= j2_nxt;
      n_r       <= n_nxt;
      pos_r     <= '0;
    end else if (q_push) begin
      pos_r <= pos_r + 1'b1;
    end
  end

endmodule

/* hw/rtl/psru_mul.sv */
module psru_mul #(
  parameter int FRAC_BITS = psru_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  psru_pkg::wide_t    a,
  input  psru_pkg::wide_t    b,
  output psru_pkg::mul_rsp_t rsp
);

  localparam int LIMB_W = psru_pkg::WIDE_W / 2;
  localparam int PROD_W = 2 * psru_pkg::WIDE_W;

  psru_pkg::mul_state_t state_r, state_nxt;
  logic [psru_pkg::WIDE_W-1:0] ua_r, ub_r;
  logic                        neg_r;
  logic [1:0]                  cnt_r;
  logic [PROD_W-1:0]           acc_r;

  logic [LIMB_W-1:0]   la, lb;
  logic [2*LIMB_W-1:0] pp;
  logic [PROD_W-1:0]   pp_sh, rsum, rq;
  logic                sat;

  // One 24x24 partial product per cycle
  assign la = cnt_r[1] ? ua_r[psru_pkg::WIDE_W-1:LIMB_W] : ua_r[LIMB_W-1:0];
  assign lb = cnt_r[0] ? ub_r[psru_pkg::WIDE_W-1:LIMB_W] : ub_r[LIMB_W-1:0];
  assign pp = la * lb;

  always_comb begin
    case ({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]})
      2'd0:    pp_sh = PROD_W'(pp);
      2'd1:    pp_sh = PROD_W'(pp) << LIMB_W;
      default: pp_sh = PROD_W'(pp) << (2 * LIMB_W);
    endcase
  end

  // Round half away from zero on the magnitude, then saturate
  assign rsum = acc_r + (PROD_W'(1) << (FRAC_BITS - 1));
  assign rq   = rsum >> FRAC_BITS;
  assign sat  = |rq[PROD_W-1:psru_pkg::WIDE_W-1];

  always_comb begin
    state_nxt = state_r;
    rsp.done  = 1'b0;
    rsp.sat   = sat;
    if (sat) begin
      rsp.res = neg_r ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end else if (neg_r) begin
      rsp.res = -$signed(rq[psru_pkg::WIDE_W-1:0]);
    end else begin
      rsp.res = $signed(rq[psru_pkg::WIDE_W-1:0]);
    end
    unique case (state_r)
      psru_pkg::MS_IDLE:  if (start) state_nxt = psru_pkg::MS_PROD;
      psru_pkg::MS_PROD:  if (cnt_r == 2'd3) state_nxt = psru_pkg::MS_ROUND;
      psru_pkg::MS_ROUND: begin
        rsp.done  = 1'b1;
        state_nxt = psru_pkg::MS_IDLE;
      end
      default: state_nxt = psru_pkg::MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psru_pkg::MS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand magnitudes and product accumulator
  always_ff @(posedge clk) begin
    if (state_r == psru_pkg::MS_IDLE && start) begin
      ua_r  <= a[psru_pkg::WIDE_W-1] ? -a : a;
      ub_r  <= b[psru_pkg::WIDE_W-1] ? -b : b;
      neg_r <= a[psru_pkg::WIDE_W-1] ^ b[psru_pkg::WIDE_W-1];
      acc_r <= '0;
      cnt_r <= '0;
    end else if (state_r == psru_pkg::MS_PROD) begin
      acc_r <= acc_r + pp_sh;
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

/* hw/rtl/psru_back.sv */
module psru_back #(
  parameter int FRAC_BITS = psru_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  psru_pkg::coef_t    coef,
  input  logic               q_empty,
  output logic               q_pop,
  input  psru_pkg::job_t     q_job,
  output logic               mul_start,
  output psru_pkg::wide_t    mul_a,
  output psru_pkg::wide_t    mul_b,
  input  psru_pkg::mul_rsp_t mul_rsp,
  output logic               out_valid,
  input  logic               out_ready,
  output psru_pkg::res_t     out_res
);

  localparam psru_pkg::wide_t K_HALF   = -(48'sd1 <<< (FRAC_BITS - 1));
  localparam psru_pkg::wide_t K_QUART  = -(48'sd1 <<< (FRAC_BITS - 2));
  localparam psru_pkg::wide_t K_EIGHTH = 48'sd1 <<< (FRAC_BITS - 3);

  psru_pkg::bk_state_t state_r, state_nxt;
  psru_pkg::job_t      job_r;
  logic [psru_pkg::STEP_W-1:0] step_r;
  logic                sat_r;
  logic signed [48:0]  acc_r;
  psru_pkg::word_t     dr_r, pr_r, qr_r;
  psru_pkg::res_t      res_r;
  logic                out_valid_r;
  psru_pkg::wide_t     scr_mem [psru_pkg::SCR_DEPTH];
  psru_pkg::wide_t     rdx_r, rdy_r;

  psru_pkg::uop_t  uop;
  psru_pkg::wide_t opx, opy;
  psru_pkg::wsat_t wres;
  psru_pkg::nsat_t nres;
  logic            wr_en, step_inc, load_job, load_out, acc_ld, out_ld;
  logic            sat_set;

  function automatic psru_pkg::wide_t opnd(input logic [5:0] code,
                                           input psru_pkg::wide_t rd,
                                           input psru_pkg::job_t j,
                                           input psru_pkg::coef_t c);
    psru_pkg::wide_t v;
    if (code[5]) begin
      v = rd;
    end else begin
      unique case (code)
        psru_pkg::SRC_B_RHO:  v = 48'(j.b.rho);
        psru_pkg::SRC_B_P:    v = 48'(j.b.p);
        psru_pkg::SRC_B_Q:    v = 48'(j.b.q);
        psru_pkg::SRC_C_RHO:  v = 48'(j.c.rho);
        psru_pkg::SRC_C_P:    v = 48'(j.c.p);
        psru_pkg::SRC_C_Q:    v = 48'(j.c.q);
        psru_pkg::SRC_A_RHO:  v = 48'(j.a.rho);
        psru_pkg::SRC_A_P:    v = 48'(j.a.p);
        psru_pkg::SRC_A_Q:    v = 48'(j.a.q);
        psru_pkg::SRC_DIFF:   v = 48'(c.diff);
        psru_pkg::SRC_BETA:   v = 48'(c.beta);
        psru_pkg::SRC_GAMMA:  v = 48'(c.gamma);
        psru_pkg::SRC_MUS:    v = 48'(c.mu_slope);
        psru_pkg::SRC_MUO:    v = 48'(c.mu_offset);
        psru_pkg::SRC_XI:     v = 48'(c.xi);
        psru_pkg::SRC_HALF:   v = K_HALF;
        psru_pkg::SRC_QUART:  v = K_QUART;
        psru_pkg::SRC_EIGHTH: v = K_EIGHTH;
        default:              v = '0;
      endcase
    end
    return v;
  endfunction

  assign uop       = psru_pkg::uop_rom(step_r);
  assign opx       = opnd(uop.sx, rdx_r, job_r, coef);
  assign opy       = opnd(uop.sy, rdy_r, job_r, coef);
  assign mul_a     = opx;
  assign mul_b     = opy;
  assign nres      = psru_pkg::clamp_out(opx);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign load_out  = !out_valid_r || out_ready;

  // Result of the non-multiply operations
  always_comb begin
    case (uop.op)
      psru_pkg::OP_SUB:  wres = psru_pkg::clamp_wide(52'(opx) - 52'(opy));
      psru_pkg::OP_LAPB: wres = psru_pkg::clamp_wide(52'(acc_r) - (52'(opx) <<< 1));
      default:           wres = psru_pkg::clamp_wide(52'(opx) + 52'(opy));
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_job  = 1'b0;
    mul_start = 1'b0;
    wr_en     = 1'b0;
    step_inc  = 1'b0;
    acc_ld    = 1'b0;
    out_ld    = 1'b0;
    sat_set   = 1'b0;
    unique case (state_r)
      psru_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          load_job  = 1'b1;
          state_nxt = psru_pkg::BK_FETCH;
        end
      end
      psru_pkg::BK_FETCH: state_nxt = psru_pkg::BK_EXEC;
      psru_pkg::BK_EXEC: begin
        unique case (uop.op)
          psru_pkg::OP_MUL: mul_start = 1'b1;
          psru_pkg::OP_LAPA: acc_ld = 1'b1;
          psru_pkg::OP_ADD, psru_pkg::OP_SUB, psru_pkg::OP_LAPB: begin
            wr_en   = 1'b1;
            sat_set = wres.sat;
          end
          default: begin
            out_ld  = 1'b1;
            sat_set = nres.sat;
          end
        endcase
        if (uop.op == psru_pkg::OP_MUL) begin
          state_nxt = psru_pkg::BK_MULW;
        end else if (uop.fin) begin
          state_nxt = psru_pkg::BK_EMIT;
        end else begin
          step_inc  = 1'b1;
          state_nxt = psru_pkg::BK_FETCH;
        end
      end
      psru_pkg::BK_MULW: begin
        if (mul_rsp.done) begin
          wr_en     = 1'b1;
          sat_set   = mul_rsp.sat;
          step_inc  = 1'b1;
          state_nxt = psru_pkg::BK_FETCH;
        end
      end
      psru_pkg::BK_EMIT: begin
        if (load_out) state_nxt = psru_pkg::BK_IDLE;
      end
      default: state_nxt = psru_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psru_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == psru_pkg::BK_EMIT && load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scratch memory for intermediates
  always_ff @(posedge clk) begin
    if (wr_en) begin
      scr_mem[uop.dst] <= (state_r == psru_pkg::BK_MULW) ? mul_rsp.res : wres.val;
    end
    rdx_r <= scr_mem[uop.sx[psru_pkg::SCR_AW-1:0]];
    rdy_r <= scr_mem[uop.sy[psru_pkg::SCR_AW-1:0]];
  end

  // Job, step and rate registers
  always_ff @(posedge clk) begin
    if (load_job) begin
      job_r  <= q_job;
      step_r <= '0;
      sat_r  <= 1'b0;
    end else begin
      if (step_inc) step_r <= step_r + 1'b1;
      if (sat_set) sat_r <= 1'b1;
    end
    if (acc_ld) acc_r <= 49'(opx) + 49'(opy);
    if (out_ld) begin
      case (uop.op)
        psru_pkg::OP_OUTD: dr_r <= nres.val;
        psru_pkg::OP_OUTP: pr_r <= nres.val;
        default:           qr_r <= nres.val;
      endcase
    end
    if (state_r == psru_pkg::BK_EMIT && load_out) begin
      res_r.idx  <= job_r.idx;
      res_r.dr   <= dr_r;
      res_r.pr   <= pr_r;
      res_r.qr   <= qr_r;
      res_r.sat  <= sat_r;
      res_r.last <= job_r.last;
    end
  end

endmodule

/* hw/rtl/periodic_stencil_rate_update.sv */
// Each point is classified in the front end; each result then runs through the back end
// (28 multiplies on the shared 4-pass 24x24 multiplier and 25 FETCH/EXEC steps).
// An item ending a sweep yields up to three results, other items at most one; the front
// end takes no new item until the results of the last one have gone into the queue.
// Reset (rst_n, synchronous, active low) clears the window, point count, queue,
// sequencers and coefficients; no result is pending after reset.
module periodic_stencil_rate_update #(
  parameter int GRID_POINTS = psru_pkg::GRID_POINTS_DEF,
  parameter int FRAC_BITS   = psru_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // density_in [31:0], real_in [63:32], imag_in [95:64]
  input  logic [psru_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // point_index [7:0], density_rate [39:8], real_rate [71:40], imag_rate [103:72]
  output logic [psru_pkg::OUT_TDATA_W-1:0] out_tdata,
  // saturated [0]
  output logic                             out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psru_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [psru_pkg::DATA_W-1:0]      cfg_data
);

  psru_pkg::coef_t    coef_r;
  logic               q_push, q_full, q_pop, q_empty;
  logic [psru_pkg::QUEUE_AW:0] q_count;
  psru_pkg::job_t     q_in, q_out;
  logic               mul_start;
  psru_pkg::wide_t    mul_a, mul_b;
  psru_pkg::mul_rsp_t mul_rsp;
  psru_pkg::res_t     res;

  assign cfg_ready = 1'b1;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psru_pkg::REG_DIFF:      coef_r.diff      <= cfg_data;
        psru_pkg::REG_BETA:      coef_r.beta      <= cfg_data;
        psru_pkg::REG_GAMMA:     coef_r.gamma     <= cfg_data;
        psru_pkg::REG_MU_SLOPE:  coef_r.mu_slope  <= cfg_data;
        psru_pkg::REG_MU_OFFSET: coef_r.mu_offset <= cfg_data;
        psru_pkg::REG_XI:        coef_r.xi        <= cfg_data;
        default: ;
      endcase
    end
  end

  psru_front #(.GRID_POINTS(GRID_POINTS)) u_front (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_push, .q_job(q_in), .q_full
  );

  psru_queue u_queue (
    .clk, .rst_n,
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty), .count(q_count)
  );

  psru_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk, .rst_n,
    .start(mul_start), .a(mul_a), .b(mul_b), .rsp(mul_rsp)
  );

  psru_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .coef(coef_r),
    .q_empty, .q_pop, .q_job(q_out),
    .mul_start, .mul_a, .mul_b, .mul_rsp,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {res.qr, res.pr, res.dr, res.idx};
  assign out_tuser = res.sat;
  assign out_tlast = res.last;

  // A point that ends the sweep always leaves results to hand to the queue
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("front ready right after a sweep-ending point");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= (psru_pkg::QUEUE_AW+1)'(psru_pkg::QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end took a job from an empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

/* tb/tb_periodic_stencil_rate_update.sv */
`timescale 1ns / 100ps

module tb_periodic_stencil_rate_update;
  import psru_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int GRID      = GRID_POINTS_DEF;
  localparam int DRAIN_CYC = 900;
  localparam int WDOG_MAX  = 8000;
  localparam logic [REG_IDX_W-1:0] REG_PAST_END = 8'd6;
  localparam logic [REG_IDX_W-1:0] REG_FAR      = 8'hFF;
  localparam logic signed [63:0] WMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] WMIN = -64'sh0000_8000_0000_0000;

  typedef struct {
    word_t rho;
    word_t p;
    word_t q;
    logic  last;
  } grid_item_t;

  typedef logic signed [63:0] w64_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  periodic_stencil_rate_update i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  grid_item_t pending_points[$];
  res_t       expected_rates[$];

  // predictor state
  w64_t   coef[6];
  point_t head_pts[2];
  point_t tail_pts[2];
  int     seen_cnt;
  logic   rate_sat;

  int errors = 0;
  int n_items = 0;
  int n_rates = 0;
  int n_sat = 0;
  int n_sweeps = 0;
  int idle_cnt = 0;
  logic in_acc = 1'b0;
  int in_gap = 0;
  int out_stall = 0;
  logic gaps_on = 1'b1;

  // ---------------- fixed-point predictor ----------------
  function automatic w64_t clamp48(input w64_t v);
    if (v > WMAX) begin
      rate_sat = 1'b1;
      return WMAX;
    end
    if (v < WMIN) begin
      rate_sat = 1'b1;
      return WMIN;
    end
    return v;
  endfunction

  // product shifted by FRAC, rounded half away from zero, saturated to 48 bits
  function automatic w64_t fx_mul(input w64_t a, input w64_t b);
    logic [127:0] ma, mb, prod;
    logic neg;
    ma = a < 0 ? 128'(-a) : 128'(a);
    mb = b < 0 ? 128'(-b) : 128'(b);
    neg = (a < 0) != (b < 0);
    prod = ((ma * mb) + (128'd1 << (FRAC - 1))) >> FRAC;
    if (prod > 128'(WMAX)) begin
      rate_sat = 1'b1;
      return neg ? WMIN : WMAX;
    end
    return neg ? -w64_t'(prod) : w64_t'(prod);
  endfunction

  function automatic w64_t lap3(input w64_t b, input w64_t c, input w64_t a);
    return clamp48(a + b - 2 * c);
  endfunction

  function automatic word_t to_rate(input w64_t v);
    if (v > 64'sh7FFF_FFFF) begin
      rate_sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      rate_sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic res_t stencil_rates(input int idx, input point_t b, input point_t c,
                                         input point_t a, input logic last);
    w64_t half_neg, quart_neg, eighth;
    w64_t dpq_b, dpq_c, dpq_a, pq_b, pq_c, pq_a, mu, mag, gq, xm, dr, pr, qr;
    res_t r;
    half_neg  = -(w64_t'(1) <<< (FRAC - 1));
    quart_neg = -(w64_t'(1) <<< (FRAC - 2));
    eighth    = w64_t'(1) <<< (FRAC - 3);
    rate_sat = 1'b0;
    dpq_b = clamp48(fx_mul(b.p, b.p) - fx_mul(b.q, b.q));
    dpq_c = clamp48(fx_mul(c.p, c.p) - fx_mul(c.q, c.q));
    dpq_a = clamp48(fx_mul(a.p, a.p) - fx_mul(a.q, a.q));
    pq_b = fx_mul(b.p, b.q);
    pq_c = fx_mul(c.p, c.q);
    pq_a = fx_mul(a.p, a.q);
    mu = clamp48(fx_mul(coef[REG_MU_SLOPE], c.rho) + coef[REG_MU_OFFSET]);
    mag = clamp48(fx_mul(c.p, c.p) + fx_mul(c.q, c.q));
    gq = fx_mul(coef[REG_GAMMA], c.q);
    xm = fx_mul(coef[REG_XI], mag);
    dr = fx_mul(fx_mul(coef[REG_DIFF], lap3(b.p, c.p, a.p)), half_neg);
    pr = fx_mul(fx_mul(coef[REG_DIFF], lap3(b.rho, c.rho, a.rho)), quart_neg);
    pr = clamp48(pr + fx_mul(fx_mul(coef[REG_BETA], lap3(dpq_b, dpq_c, dpq_a)), quart_neg));
    pr = clamp48(pr + fx_mul(fx_mul(gq, lap3(b.q, c.q, a.q)), eighth));
    pr = clamp48(pr + fx_mul(mu, c.p));
    pr = clamp48(pr - fx_mul(xm, c.p));
    qr = fx_mul(fx_mul(coef[REG_BETA], lap3(pq_b, pq_c, pq_a)), half_neg);
    qr = clamp48(qr - fx_mul(fx_mul(gq, lap3(b.p, c.p, a.p)), eighth));
    qr = clamp48(qr + fx_mul(mu, c.q));
    qr = clamp48(qr - fx_mul(xm, c.q));
    r.idx = idx[7:0];
    r.dr = to_rate(dr);
    r.pr = to_rate(pr);
    r.qr = to_rate(qr);
    r.sat = rate_sat;
    r.last = last;
    return r;
  endfunction

  // advance the grid window by one point and queue the rates it releases
  task automatic take_point(input point_t cur, input logic tl);
    int k;
    logic last;
    k = seen_cnt;
    last = tl || (k >= GRID - 1);
    if (k == 0) begin
      head_pts[0] = cur;
      if (last) expected_rates.push_back(stencil_rates(0, cur, cur, cur, 1'b1));
    end else if (k == 1) begin
      head_pts[1] = cur;
      if (last) begin
        expected_rates.push_back(stencil_rates(0, cur, head_pts[0], cur, 1'b0));
        expected_rates.push_back(stencil_rates(1, head_pts[0], cur, head_pts[0], 1'b1));
      end
    end else begin
      expected_rates.push_back(stencil_rates(k - 1, tail_pts[0], tail_pts[1], cur, 1'b0));
      if (last) begin
        expected_rates.push_back(stencil_rates(k, tail_pts[1], cur, head_pts[0], 1'b0));
        expected_rates.push_back(stencil_rates(0, cur, head_pts[0], head_pts[1], 1'b1));
      end
    end
    tail_pts[0] = tail_pts[1];
    tail_pts[1] = cur;
    seen_cnt = last ? 0 : k + 1;
    if (last) n_sweeps++;
  endtask

  // ---------------- monitor, predictor update, watchdog ----------------
  always @(posedge clk) begin
    res_t got, exp_r;
    point_t pt;
    logic busy;
    busy = 1'b0;
    in_acc <= in_tvalid && in_tready;
    if (rst_n && cfg_valid && cfg_ready) begin
      busy = 1'b1;
      if (cfg_index < 6) coef[cfg_index] = w64_t'($signed(cfg_data));
    end
    if (rst_n && out_tvalid && out_tready) begin
      busy = 1'b1;
      got.idx = out_tdata[7:0];
      got.dr = out_tdata[39:8];
      got.pr = out_tdata[71:40];
      got.qr = out_tdata[103:72];
      got.sat = out_tuser;
      got.last = out_tlast;
      n_rates++;
      if (got.sat) n_sat++;
      if (expected_rates.size() == 0) begin
        $error("unexpected rate transaction for point %0d", got.idx);
        errors++;
      end else begin
        exp_r = expected_rates.pop_front();
        if (got.idx != exp_r.idx) begin
          $error("point_index exp %0d got %0d", exp_r.idx, got.idx); errors++;
        end
        if (got.dr != exp_r.dr) begin
          $error("density_rate exp %h got %h", exp_r.dr, got.dr); errors++;
        end
        if (got.pr != exp_r.pr) begin
          $error("real_rate exp %h got %h", exp_r.pr, got.pr); errors++;
        end
        if (got.qr != exp_r.qr) begin
          $error("imag_rate exp %h got %h", exp_r.qr, got.qr); errors++;
        end
        if (got.sat != exp_r.sat) begin
          $error("saturated exp %0b got %0b", exp_r.sat, got.sat); errors++;
        end
        if (got.last != exp_r.last) begin
          $error("last_of_sweep exp %0b got %0b", exp_r.last, got.last); errors++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      busy = 1'b1;
      pt.rho = in_tdata[31:0];
      pt.p = in_tdata[63:32];
      pt.q = in_tdata[95:64];
      take_point(pt, in_tlast);
      n_items++;
    end
    idle_cnt = busy ? 0 : idle_cnt + 1;
    if (idle_cnt >= WDOG_MAX) begin
      $display("timeout: no transaction for %0d cycles", WDOG_MAX);
      $display("tb_periodic_stencil_rate_update: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- drivers ----------------
  always @(negedge clk) begin
    grid_item_t it;
    if ($urandom_range(0, 99) == 0) gaps_on <= ~gaps_on;
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_points.size() > 0) begin
        it = pending_points.pop_front();
        in_tdata <= {it.q, it.p, it.rho};
        in_tlast <= it.last;
        in_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      out_stall <= pick_gap();
    end
  end

  // ---------------- stimulus ----------------
  function automatic word_t rand_val(input int kind);
    int r;
    case (kind)
      0: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      1: return $urandom;
      default: begin
        r = $urandom_range(0, 3);
        return r == 0 ? 32'sh7FFF_FFFF : r == 1 ? 32'sh8000_0000 : r == 2 ? 32'sh0 : -32'sh1;
      end
    endcase
  endfunction

  task automatic add_point(input word_t rho, input word_t p, input word_t q, input logic last);
    grid_item_t it;
    it.rho = rho;
    it.p = p;
    it.q = q;
    it.last = last;
    pending_points.push_back(it);
  endtask

  task automatic add_sweep(input int len, input int kind);
    int k, r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      k = kind >= 0 ? kind : (r < 70 ? 0 : r < 92 ? 1 : 2);
      add_point(rand_val(k), rand_val(k), rand_val(k), i == len - 1);
    end
  endtask

  task automatic add_random_sweeps(input int n);
    int len;
    while (n > 0) begin
      len = $urandom_range(0, 9) == 0 ? $urandom_range(10, 20) : $urandom_range(1, 6);
      if (len > n) len = n;
      add_sweep(len, -1);
      n -= len;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_points.size() != 0 || in_tvalid || expected_rates.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // kind: 0 moderate, 1 all max, 2 all min, 3 full random, 4 zero
  task automatic load_coefs(input int kind);
    logic [DATA_W-1:0] v;
    for (int i = 0; i < 6; i++) begin
      case (kind)
        0: v = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h8000_0000;
        3: v = $urandom;
        default: v = '0;
      endcase
      write_reg(REG_IDX_W'(i), v);
    end
    // writes past the register list must be dropped
    write_reg(REG_PAST_END, $urandom);
    write_reg(REG_FAR, $urandom);
  endtask

  initial begin
    for (int i = 0; i < 6; i++) coef[i] = 0;
    head_pts = '{default: '0};
    tail_pts = '{default: '0};
    seen_cnt = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: degenerate and short sweeps, field extremes
    load_coefs(0);
    add_point(32'sh0100_0000, 32'sh0080_0000, -32'sh0040_0000, 1'b1);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    add_point(32'sh0, 32'sh0, 32'sh0, 1'b0);
    add_point(-32'sh1, -32'sh1, -32'sh1, 1'b0);
    add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0100_0000, 1'b1);
    add_sweep(4, 2);
    add_sweep(3, 0);
    add_sweep(5, 1);
    add_point(32'sh0200_0000, -32'sh0100_0000, 32'sh0180_0000, 1'b1);
    add_sweep(2, 0);
    wait_drained();

    // random phases under varying coefficient settings
    for (int ph = 0; ph < 6; ph++) begin
      load_coefs(ph == 5 ? 4 : ph == 4 ? 0 : ph);
      add_random_sweeps(7);
      // sender holds off until all rates are back
      wait_drained();
      add_random_sweeps(7);
      // sweep without an end marker: forced end at the grid size
      if (ph == 0) add_sweep(GRID, 0);
      if (ph == 0) pending_points[pending_points.size() - 1].last = 1'b0;
      wait_drained();
    end

    $display("covered %0d grid points in %0d sweeps, %0d rate transactions (%0d saturated)",
             n_items, n_sweeps, n_rates, n_sat);
    $display("coefficient settings: zero, moderate, all max, all min, random");
    if (errors == 0) begin
      $display("tb_periodic_stencil_rate_update: PASS");
    end else begin
      $display("tb_periodic_stencil_rate_update: FAIL");
    end
    $finish;
  end

endmodule
